/* rtl/mcrt_pkg.sv */
`timescale 1ns / 1ps

package mcrt_pkg;

    // Input item kinds, carried in the low bits of s_tuser.
    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_READ  = 2'd1,
        FN_WRITE = 2'd2
    } func_t;

    // Per-timer register map.
    typedef enum logic [1:0] {
        REG_TIME = 2'd0,
        REG_LOAD = 2'd1,
        REG_CTRL = 2'd2,
        REG_STAT = 2'd3
    } reg_sel_t;

    // Control register bits.
    localparam int CTRL_IRQE_BIT = 0;
    localparam int CTRL_PRDC_BIT = 1;

    // Field widths fixed by the register interface.
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int TSEL_W   = 2;
    localparam int RSEL_W   = 2;
    localparam int IRQ_W    = 4;
    localparam int COUNT_W  = 64;
    localparam int USER_W   = FUNC_W + TSEL_W + RSEL_W;
    localparam int RES_W    = DATA_W + IRQ_W + 1;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    // Commands from the access decoder to one timer.
    typedef struct packed {
        logic tick;
        logic load_we;
        logic ctrl_we;
        logic stat_clr;
    } tmr_cmd_t;

    // What one timer reports back.
    typedef struct packed {
        logic [DATA_W-1:0] reload;
        logic              expired;
        logic              irq_next;
    } tmr_stat_t;

endpackage

/* rtl/mcrt_timer.sv */
`timescale 1ns / 1ps

module mcrt_timer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mcrt_pkg::tmr_cmd_t        cmd,
    input  logic [mcrt_pkg::DATA_W-1:0] wdata,
    output mcrt_pkg::tmr_stat_t       stat
);

    logic [mcrt_pkg::DATA_W-1:0] reload_reg, reload_next;
    logic [mcrt_pkg::DATA_W-1:0] remain_reg, remain_next;
    logic                        run_reg, run_next;
    logic                        irqe_reg, irqe_next;
    logic                        prdc_reg, prdc_next;
    logic                        expd_reg, expd_next;
    logic                        irq_reg, irq_next;
    logic [mcrt_pkg::DATA_W-1:0] remain_dec;

    assign remain_dec = remain_reg - mcrt_pkg::DATA_W'(1);

    // Countdown, expiry and register side effects for this timer.
    always_comb begin
        reload_next = reload_reg;
        remain_next = remain_reg;
        run_next    = run_reg;
        irqe_next   = irqe_reg;
        prdc_next   = prdc_reg;
        expd_next   = expd_reg;
        irq_next    = irq_reg;
        if (cmd.tick && run_reg) begin
            remain_next = remain_dec;
            if (remain_dec == '0) begin
                expd_next = 1'b1;
                if (irqe_reg) begin
                    irq_next = 1'b1;
                end
                if (prdc_reg && (reload_reg != '0)) begin
                    remain_next = reload_reg;
                end else begin
                    run_next = 1'b0;
                end
            end
        end
        if (cmd.load_we) begin
            reload_next = wdata;
        end
        if (cmd.ctrl_we) begin
            irqe_next = wdata[mcrt_pkg::CTRL_IRQE_BIT];
            prdc_next = wdata[mcrt_pkg::CTRL_PRDC_BIT];
            run_next  = (reload_reg != '0);
            // A control write always restarts from the current reload.
            remain_next = reload_reg;
        end
        if (cmd.stat_clr) begin
            expd_next = 1'b0;
            irq_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= '0;
            remain_reg <= '0;
            run_reg    <= 1'b0;
            irqe_reg   <= 1'b0;
            prdc_reg   <= 1'b0;
            expd_reg   <= 1'b0;
            irq_reg    <= 1'b0;
        end else begin
            reload_reg <= reload_next;
            remain_reg <= remain_next;
            run_reg    <= run_next;
            irqe_reg   <= irqe_next;
            prdc_reg   <= prdc_next;
            expd_reg   <= expd_next;
            irq_reg    <= irq_next;
        end
    end

    assign stat.reload   = reload_reg;
    assign stat.expired  = expd_reg;
    assign stat.irq_next = irq_next;

endmodule

/* rtl/multi_channel_reload_timer.sv */
`timescale 1ns / 1ps

// Bank of TIMERS countdown timers with a shared 64-bit nanosecond counter,
// driven by one stream of beats: ticks, register reads and register writes.
// Every input beat gives exactly one result beat. The block takes one beat
// per clock cycle while the output is not stalled. A beat passes an input
// register and then a result register, whose contents drive m_tdata; the
// result is taken when m_tready is high. The whole update (64-bit counter
// increment, all timer decrements in parallel and the register access)
// happens in the single step between those two registers. When the result
// register is held by m_tready low, the input register keeps one more beat
// and then s_tready drops.
module multi_channel_reload_timer #(
    parameter int TIMERS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] write_data
    input  logic [mcrt_pkg::DATA_W-1:0]   s_tdata,
    // [1:0] func, [3:2] timer_select, [5:4] reg_select
    input  logic [mcrt_pkg::USER_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] read_data, [35:32] irq_lines, [36] access_error, [39:37] zero
    output logic [mcrt_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int TS_LO = mcrt_pkg::FUNC_W;
    localparam int RS_LO = mcrt_pkg::FUNC_W + mcrt_pkg::TSEL_W;

    // Input register.
    logic                          in_vld_reg;
    logic [mcrt_pkg::FUNC_W-1:0]   in_func_reg;
    logic [mcrt_pkg::TSEL_W-1:0]   in_tsel_reg;
    logic [mcrt_pkg::RSEL_W-1:0]   in_rsel_reg;
    logic [mcrt_pkg::DATA_W-1:0]   in_wdata_reg;

    // Result register.
    logic                          out_vld_reg;
    logic [mcrt_pkg::DATA_W-1:0]   out_rdata_reg, out_rdata_next;
    logic [mcrt_pkg::IRQ_W-1:0]    out_irq_reg, out_irq_next;
    logic                          out_err_reg, out_err_next;

    logic [mcrt_pkg::COUNT_W-1:0]  ns_count_reg;

    logic                          adv;
    logic                          in_range;
    logic                          is_tick, rd_ok, wr_ok;
    logic                          do_load_we, do_ctrl_we, do_stat_rd;
    logic [TIMERS-1:0]             hit;
    mcrt_pkg::tmr_cmd_t            cmd   [TIMERS];
    mcrt_pkg::tmr_stat_t           stat  [TIMERS];
    logic [mcrt_pkg::DATA_W-1:0]   sel_reload;
    logic                          sel_expired;

    // The stored beat moves on when the result register is free or drained.
    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg  <= s_tuser[mcrt_pkg::FUNC_W-1:0];
            in_tsel_reg  <= s_tuser[TS_LO +: mcrt_pkg::TSEL_W];
            in_rsel_reg  <= s_tuser[RS_LO +: mcrt_pkg::RSEL_W];
            in_wdata_reg <= s_tdata;
        end
    end

    // Timer address decode.
    generate
        for (genvar t = 0; t < TIMERS; t++) begin : g_hit
            assign hit[t] = (int'(in_tsel_reg) == t);
        end
    endgenerate

    assign in_range = (int'(in_tsel_reg) < TIMERS);

    // Read mux over the addressed timer.
    always_comb begin
        sel_reload  = '0;
        sel_expired = 1'b0;
        for (int t = 0; t < TIMERS; t++) begin
            if (hit[t]) begin
                sel_reload  = sel_reload | stat[t].reload;
                sel_expired = sel_expired | stat[t].expired;
            end
        end
    end

    // Access decode, error check and read data.
    always_comb begin
        is_tick        = 1'b0;
        rd_ok          = 1'b0;
        wr_ok          = 1'b0;
        do_load_we     = 1'b0;
        do_ctrl_we     = 1'b0;
        do_stat_rd     = 1'b0;
        out_rdata_next = '0;
        out_err_next   = 1'b0;
        unique case (in_func_reg)
            mcrt_pkg::FN_TICK: begin
                is_tick = 1'b1;
            end
            mcrt_pkg::FN_READ: begin
                rd_ok        = in_range;
                out_err_next = !in_range;
            end
            mcrt_pkg::FN_WRITE: begin
                wr_ok        = in_range;
                out_err_next = !in_range;
            end
            default: begin
                out_err_next = 1'b1;
            end
        endcase
        if (rd_ok) begin
            unique case (in_rsel_reg)
                mcrt_pkg::REG_TIME: out_rdata_next = ns_count_reg[mcrt_pkg::DATA_W-1:0];
                mcrt_pkg::REG_LOAD: out_rdata_next = sel_reload;
                mcrt_pkg::REG_STAT: begin
                    out_rdata_next = mcrt_pkg::DATA_W'(sel_expired);
                    do_stat_rd     = 1'b1;
                end
                mcrt_pkg::REG_CTRL: out_err_next = 1'b1;
            endcase
        end
        if (wr_ok) begin
            unique case (in_rsel_reg)
                mcrt_pkg::REG_LOAD: do_load_we   = 1'b1;
                mcrt_pkg::REG_CTRL: do_ctrl_we   = 1'b1;
                mcrt_pkg::REG_TIME,
                mcrt_pkg::REG_STAT: out_err_next = 1'b1;
            endcase
        end
    end

    // Nanosecond counter, advanced by each accepted tick beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ns_count_reg <= '0;
        end else if (adv && is_tick) begin
            ns_count_reg <= ns_count_reg + mcrt_pkg::COUNT_W'(1);
        end
    end

    // One timer instance per channel.
    generate
        for (genvar t = 0; t < TIMERS; t++) begin : g_tmr
            assign cmd[t].tick     = adv && is_tick;
            assign cmd[t].load_we  = adv && do_load_we && hit[t];
            assign cmd[t].ctrl_we  = adv && do_ctrl_we && hit[t];
            assign cmd[t].stat_clr = adv && do_stat_rd && hit[t];

            mcrt_timer u_tmr (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd[t]),
                .wdata   (in_wdata_reg),
                .stat    (stat[t])
            );
        end
    endgenerate

    // Interrupt lines after the update; timers beyond the first four have none.
    generate
        for (genvar i = 0; i < mcrt_pkg::IRQ_W; i++) begin : g_irq
            if (i < TIMERS) begin : g_on
                assign out_irq_next[i] = stat[i].irq_next;
            end else begin : g_off
                assign out_irq_next[i] = 1'b0;
            end
        end
    endgenerate

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_rdata_reg <= out_rdata_next;
            out_irq_reg   <= out_irq_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = mcrt_pkg::M_DATA_W'({out_err_reg, out_irq_reg, out_rdata_reg});

endmodule

/* rtl/mcrt_checker.sv */
`timescale 1ns / 1ps

module mcrt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mcrt_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int ERR_BIT = mcrt_pkg::DATA_W + mcrt_pkg::IRQ_W;

    // A held result beat keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The input side only stalls behind a held result beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // An access error never carries read data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[ERR_BIT] |-> m_tdata[mcrt_pkg::DATA_W-1:0] == '0)
        else $error("read data on an access error");

    // Padding bits of the result beat stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[mcrt_pkg::M_DATA_W-1:ERR_BIT+1] == '0)
        else $error("nonzero padding in result beat");

endmodule

bind multi_channel_reload_timer mcrt_checker u_mcrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/tb_multi_channel_reload_timer.sv */
`timescale 1ns / 1ps

module tb_multi_channel_reload_timer;

    localparam int TIMERS = 4;
    localparam int HALF_PERIOD = 10;
    localparam int RANDOM_BEATS = 1750;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;

    // The func code left unused by the block; it must come back as an access error.
    localparam logic [mcrt_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

    // One register access or tick as it travels on the input stream.
    typedef struct packed {
        logic [mcrt_pkg::FUNC_W-1:0] fn;
        logic [mcrt_pkg::TSEL_W-1:0] tsel;
        logic [mcrt_pkg::RSEL_W-1:0] rsel;
        logic [mcrt_pkg::DATA_W-1:0] wdata;
    } access_t;

    // One result beat, split into its fields.
    typedef struct packed {
        logic [mcrt_pkg::DATA_W-1:0] rdata;
        logic [mcrt_pkg::IRQ_W-1:0]  irq;
        logic                        err;
    } timer_result_t;

    // A directed row: the access, and a typed result where one is given.
    typedef struct packed {
        access_t       acc;
        logic          typed;
        timer_result_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        // Reset values and illegal accesses.
        '{'{mcrt_pkg::FN_READ, 2'd0, mcrt_pkg::REG_TIME, 32'h0}, 1'b1, '{32'h0, 4'h0, 1'b0}},
        '{'{mcrt_pkg::FN_READ, 2'd3, mcrt_pkg::REG_STAT, 32'h0}, 1'b1, '{32'h0, 4'h0, 1'b0}},
        '{'{mcrt_pkg::FN_READ, 2'd2, mcrt_pkg::REG_CTRL, 32'hFFFFFFFF}, 1'b1,
          '{32'h0, 4'h0, 1'b1}},
        '{'{mcrt_pkg::FN_WRITE, 2'd1, mcrt_pkg::REG_TIME, 32'hFFFFFFFF}, 1'b1,
          '{32'h0, 4'h0, 1'b1}},
        '{'{mcrt_pkg::FN_WRITE, 2'd3, mcrt_pkg::REG_STAT, 32'hFFFFFFFF}, 1'b1,
          '{32'h0, 4'h0, 1'b1}},
        '{'{FN_UNUSED, 2'd3, mcrt_pkg::REG_STAT, 32'hFFFFFFFF}, 1'b1, '{32'h0, 4'h0, 1'b1}},
        // Reload maximum read back, then the reload set to zero.
        '{'{mcrt_pkg::FN_WRITE, 2'd0, mcrt_pkg::REG_LOAD, 32'hFFFFFFFF}, 1'b1,
          '{32'h0, 4'h0, 1'b0}},
        '{'{mcrt_pkg::FN_READ, 2'd0, mcrt_pkg::REG_LOAD, 32'h0}, 1'b1,
          '{32'hFFFFFFFF, 4'h0, 1'b0}},
        '{'{mcrt_pkg::FN_WRITE, 2'd0, mcrt_pkg::REG_LOAD, 32'h0}, 1'b0, '0},
        // Control write with a zero reload leaves the timer stopped.
        '{'{mcrt_pkg::FN_WRITE, 2'd0, mcrt_pkg::REG_CTRL, 32'h3}, 1'b0, '0},
        '{'{mcrt_pkg::FN_TICK, 2'd0, mcrt_pkg::REG_TIME, 32'h0}, 1'b0, '0},
        '{'{mcrt_pkg::FN_READ, 2'd0, mcrt_pkg::REG_TIME, 32'h0}, 1'b0, '0},
        // Periodic timer with interrupt, then interrupt enable cleared.
        '{'{mcrt_pkg::FN_WRITE, 2'd1, mcrt_pkg::REG_LOAD, 32'h2}, 1'b0, '0},
        '{'{mcrt_pkg::FN_WRITE, 2'd1, mcrt_pkg::REG_CTRL, 32'h3}, 1'b0, '0},
        '{'{mcrt_pkg::FN_TICK, 2'd0, mcrt_pkg::REG_TIME, 32'h0}, 1'b0, '0},
        '{'{mcrt_pkg::FN_TICK, 2'd0, mcrt_pkg::REG_TIME, 32'h0}, 1'b0, '0},
        '{'{mcrt_pkg::FN_WRITE, 2'd1, mcrt_pkg::REG_CTRL, 32'hFFFFFFFE}, 1'b0, '0},
        '{'{mcrt_pkg::FN_TICK, 2'd0, mcrt_pkg::REG_TIME, 32'h0}, 1'b0, '0},
        '{'{mcrt_pkg::FN_TICK, 2'd0, mcrt_pkg::REG_TIME, 32'h0}, 1'b0, '0},
        '{'{mcrt_pkg::FN_READ, 2'd1, mcrt_pkg::REG_STAT, 32'h0}, 1'b0, '0},
        '{'{mcrt_pkg::FN_READ, 2'd1, mcrt_pkg::REG_STAT, 32'h0}, 1'b0, '0},
        // One-shot timer stops after its expiry.
        '{'{mcrt_pkg::FN_WRITE, 2'd2, mcrt_pkg::REG_LOAD, 32'h1}, 1'b0, '0},
        '{'{mcrt_pkg::FN_WRITE, 2'd2, mcrt_pkg::REG_CTRL, 32'h1}, 1'b0, '0},
        '{'{mcrt_pkg::FN_TICK, 2'd0, mcrt_pkg::REG_TIME, 32'h0}, 1'b0, '0},
        '{'{mcrt_pkg::FN_TICK, 2'd0, mcrt_pkg::REG_TIME, 32'h0}, 1'b0, '0},
        '{'{mcrt_pkg::FN_READ, 2'd2, mcrt_pkg::REG_STAT, 32'h0}, 1'b0, '0}
    };

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mcrt_pkg::DATA_W-1:0]   s_tdata = '0;
    logic [mcrt_pkg::USER_W-1:0]   s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mcrt_pkg::M_DATA_W-1:0] m_tdata;

    // Predicted state of the timer bank.
    logic [mcrt_pkg::COUNT_W-1:0] ns_count = '0;
    logic [mcrt_pkg::DATA_W-1:0]  reload_val [TIMERS];
    logic [mcrt_pkg::DATA_W-1:0]  count_left [TIMERS];
    logic                         active     [TIMERS];
    logic                         irq_on     [TIMERS];
    logic                         periodic   [TIMERS];
    logic                         expired    [TIMERS];
    logic                         irq_raised [TIMERS];

    timer_result_t results_due [$];
    bit idle_on = 1'b1;
    int mismatches = 0;
    int idle_cycles = 0;
    int ticks_sent = 0;
    int reads_sent = 0;
    int writes_sent = 0;
    int bad_accesses = 0;
    int expiries = 0;
    int results_seen = 0;

    always #HALF_PERIOD aclk = ~aclk;

    multi_channel_reload_timer #(
        .TIMERS(TIMERS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // Advance the predicted timer bank by one access and return its result.
    task automatic timer_bank_step(input access_t acc, output timer_result_t res);
        res = '0;
        if (acc.fn == mcrt_pkg::FN_TICK) begin
            ns_count = ns_count + mcrt_pkg::COUNT_W'(1);
            for (int t = 0; t < TIMERS; t++) begin
                if (active[t]) begin
                    count_left[t] = count_left[t] - mcrt_pkg::DATA_W'(1);
                    if (count_left[t] == '0) begin
                        expiries++;
                        expired[t] = 1'b1;
                        if (irq_on[t])
                            irq_raised[t] = 1'b1;
                        if (periodic[t] && reload_val[t] != '0)
                            count_left[t] = reload_val[t];
                        else
                            active[t] = 1'b0;
                    end
                end
            end
        end else if (acc.fn == mcrt_pkg::FN_READ || acc.fn == mcrt_pkg::FN_WRITE) begin
            if (acc.tsel >= TIMERS) begin
                res.err = 1'b1;
            end else if (acc.fn == mcrt_pkg::FN_READ) begin
                unique case (acc.rsel)
                    mcrt_pkg::REG_TIME: res.rdata = ns_count[mcrt_pkg::DATA_W-1:0];
                    mcrt_pkg::REG_LOAD: res.rdata = reload_val[acc.tsel];
                    mcrt_pkg::REG_STAT: begin
                        res.rdata = mcrt_pkg::DATA_W'(expired[acc.tsel]);
                        expired[acc.tsel] = 1'b0;
                        irq_raised[acc.tsel] = 1'b0;
                    end
                    default: res.err = 1'b1;
                endcase
            end else begin
                unique case (acc.rsel)
                    mcrt_pkg::REG_LOAD: reload_val[acc.tsel] = acc.wdata;
                    mcrt_pkg::REG_CTRL: begin
                        irq_on[acc.tsel] = acc.wdata[mcrt_pkg::CTRL_IRQE_BIT];
                        periodic[acc.tsel] = acc.wdata[mcrt_pkg::CTRL_PRDC_BIT];
                        active[acc.tsel] = reload_val[acc.tsel] != '0;
                        count_left[acc.tsel] = reload_val[acc.tsel];
                    end
                    default: res.err = 1'b1;
                endcase
            end
        end else begin
            res.err = 1'b1;
        end
        for (int t = 0; t < TIMERS && t < mcrt_pkg::IRQ_W; t++)
            res.irq[t] = irq_raised[t];
    endtask

    // Present one beat, possibly after a random gap, and wait until it is taken.
    task automatic send_beat(input access_t acc, output bit taken);
        while (idle_on && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= acc.wdata;
        s_tuser <= {acc.rsel, acc.tsel, acc.fn};
        do
            @(posedge aclk);
        while (!s_tready);
        taken = 1'b1;
        unique case (acc.fn)
            mcrt_pkg::FN_TICK:  ticks_sent++;
            mcrt_pkg::FN_READ:  reads_sent++;
            mcrt_pkg::FN_WRITE: writes_sent++;
            default:            bad_accesses++;
        endcase
    endtask

    // Random access, weighted so that small reloads make timers expire often.
    function automatic access_t random_access();
        access_t acc;
        int pick;
        pick = $urandom_range(0, 99);
        acc.tsel = mcrt_pkg::TSEL_W'($urandom_range(0, 3));
        acc.rsel = mcrt_pkg::RSEL_W'($urandom_range(0, 3));
        acc.wdata = $urandom;
        if (pick < 45) begin
            acc.fn = mcrt_pkg::FN_TICK;
        end else if (pick < 70) begin
            acc.fn = mcrt_pkg::FN_READ;
            if ($urandom_range(0, 9) < 4)
                acc.rsel = mcrt_pkg::REG_STAT;
        end else if (pick < 97) begin
            acc.fn = mcrt_pkg::FN_WRITE;
            acc.rsel = ($urandom_range(0, 9) < 5) ? mcrt_pkg::REG_LOAD : mcrt_pkg::REG_CTRL;
            if ($urandom_range(0, 19) == 0)
                acc.rsel = $urandom_range(0, 1) ? mcrt_pkg::REG_TIME : mcrt_pkg::REG_STAT;
            if (acc.rsel == mcrt_pkg::REG_LOAD && $urandom_range(0, 3) != 0)
                acc.wdata = $urandom_range(0, 12);
        end else begin
            acc.fn = FN_UNUSED;
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [mcrt_pkg::DATA_W-1:0] got,
                                   input logic [mcrt_pkg::DATA_W-1:0] want);
        $display("ERROR at %0t ns: %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Result side: random back-pressure on the output stream.
    always @(posedge aclk) begin
        m_tready <= !idle_on || $urandom_range(0, 99) >= 32;
    end

    // Compare every result beat against the oldest pending prediction.
    always @(posedge aclk) begin : check_results
        timer_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                report_mismatch("result beat with nothing pending",
                                m_tdata[mcrt_pkg::DATA_W-1:0], '0);
            end else begin
                want = results_due.pop_front();
                if (m_tdata[mcrt_pkg::DATA_W-1:0] !== want.rdata)
                    report_mismatch("read_data", m_tdata[mcrt_pkg::DATA_W-1:0], want.rdata);
                if (m_tdata[mcrt_pkg::DATA_W +: mcrt_pkg::IRQ_W] !== want.irq)
                    report_mismatch("irq_lines",
                        mcrt_pkg::DATA_W'(m_tdata[mcrt_pkg::DATA_W +: mcrt_pkg::IRQ_W]),
                        mcrt_pkg::DATA_W'(want.irq));
                if (m_tdata[mcrt_pkg::DATA_W+mcrt_pkg::IRQ_W] !== want.err)
                    report_mismatch("access_error",
                        mcrt_pkg::DATA_W'(m_tdata[mcrt_pkg::DATA_W+mcrt_pkg::IRQ_W]),
                        mcrt_pkg::DATA_W'(want.err));
            end
        end
    end

    // Watchdog: give up when neither stream moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Main stimulus: reset, directed table, random beats, then drain.
    initial begin : stimulus
        timer_result_t res;
        access_t acc;
        bit taken;
        for (int t = 0; t < TIMERS; t++) begin
            reload_val[t] = '0;
            count_left[t] = '0;
            active[t] = 1'b0;
            irq_on[t] = 1'b0;
            periodic[t] = 1'b0;
            expired[t] = 1'b0;
            irq_raised[t] = 1'b0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows use the typed result where one is given.
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_beat(DIRECTED[i].acc, taken);
            timer_bank_step(DIRECTED[i].acc, res);
            results_due.push_back(DIRECTED[i].typed ? DIRECTED[i].want : res);
        end

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            // A long stretch with both streams running flat out.
            idle_on = !(i >= 700 && i < 1000);
            // Hold off once until every pending result has come back.
            if (i == 1200) begin
                s_tvalid <= 1'b0;
                while (results_due.size() != 0)
                    @(posedge aclk);
            end
            acc = random_access();
            send_beat(acc, taken);
            timer_bank_step(acc, res);
            results_due.push_back(res);
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d ticks, %0d reads, %0d writes and %0d unused-code beats.",
                 ticks_sent, reads_sent, writes_sent, bad_accesses);
        $display("Checked %0d result beats; %0d timer expiries predicted.",
                 results_seen, expiries);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches found.", mismatches);
            $display("FAIL");
        end
        $finish;
    end

endmodule
